// ----- design/mlfq_pkg.sv -----
// Shared constants, types and command/status structs for the MLFQ scheduler.
`default_nettype none
package mlfq_pkg;
  localparam int unsigned MaxThreads = 16;
  localparam int unsigned MaxLevels  = 8;
  localparam int unsigned TidW   = $clog2(MaxThreads);
  localparam int unsigned LvlW   = $clog2(MaxLevels);
  localparam int unsigned CntW   = $clog2(MaxThreads + 1);
  localparam int unsigned NumLvW = 4;
  localparam int unsigned TimeW  = 24;
  localparam int unsigned RunW   = 16;
  localparam int unsigned NowW   = 32;
  localparam int unsigned CfgW   = 32;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned FifoAw = LvlW + TidW;

  localparam logic [CfgIdxW-1:0] CfgNumLevels = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgAllot     = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgBoost     = 2'd2;

  typedef enum logic [3:0] {
    StIdle, StAddWr, StReqRd, StReqWr, StBoostChk, StBoostRd, StBoostWait,
    StBoostWr, StScan, StPopRd, StPopWait, StOut
  } state_e;

  typedef struct packed {
    logic load;        // capture input item
    logic add_wr;      // push added thread to top
    logic req_rd;      // read running thread record
    logic req_wr;      // re-queue running thread
    logic boost_chk;   // evaluate boost condition
    logic boost_rd;    // issue fifo read at current boost level head
    logic boost_wr;    // move read entry to top
    logic boost_done;  // stamp now
    logic lvl_dec;     // step boost level down
    logic scan_step;   // step scan level down
    logic pop_rd;      // issue fifo read at scan level head
    logic pop_fin;     // take popped entry
    logic out_set;     // present result
  } cmd_t;

  typedef struct packed {
    logic mode;
    logic requeue;     // running thread to re-queue
    logic boost;       // boost needed
    logic blvl_zero;   // boost level index reached bottom
    logic blvl_empty;  // current boost level empty
    logic top_full;
    logic slvl_zero;
    logic slvl_found;  // scan level non-empty
    logic out_busy;
  } sts_t;
endpackage
`default_nettype wire

// ----- design/mlfq_ctrl.sv -----
// Controller state machine sequencing add, re-queue, boost and dispatch.
`default_nettype none
module mlfq_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire mlfq_pkg::sts_t  sts_i,
  output mlfq_pkg::cmd_t       cmd_o
);
  mlfq_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= mlfq_pkg::StIdle;
    else state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mlfq_pkg::StIdle:
        if (in_valid_i) state_d = mlfq_pkg::StAddWr;
      mlfq_pkg::StAddWr:
        state_d = sts_i.mode ? (sts_i.requeue ? mlfq_pkg::StReqRd : mlfq_pkg::StBoostChk)
                             : mlfq_pkg::StOut;
      mlfq_pkg::StReqRd:    state_d = mlfq_pkg::StReqWr;
      mlfq_pkg::StReqWr:    state_d = mlfq_pkg::StBoostChk;
      mlfq_pkg::StBoostChk: state_d = sts_i.boost ? mlfq_pkg::StBoostRd : mlfq_pkg::StScan;
      mlfq_pkg::StBoostRd: begin
        if (sts_i.blvl_zero) state_d = mlfq_pkg::StScan;
        else if (sts_i.blvl_empty) state_d = mlfq_pkg::StBoostRd;
        else if (sts_i.top_full) state_d = mlfq_pkg::StScan;
        else state_d = mlfq_pkg::StBoostWait;
      end
      mlfq_pkg::StBoostWait: state_d = mlfq_pkg::StBoostWr;
      mlfq_pkg::StBoostWr:   state_d = mlfq_pkg::StBoostRd;
      mlfq_pkg::StScan: begin
        if (sts_i.slvl_found) state_d = mlfq_pkg::StPopRd;
        else if (sts_i.slvl_zero) state_d = mlfq_pkg::StOut;
      end
      mlfq_pkg::StPopRd:   state_d = mlfq_pkg::StPopWait;
      mlfq_pkg::StPopWait: state_d = mlfq_pkg::StOut;
      mlfq_pkg::StOut:
        if (!sts_i.out_busy) state_d = mlfq_pkg::StIdle;
      default: state_d = mlfq_pkg::StIdle;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    in_stall_o = (state_q != mlfq_pkg::StIdle);
    unique case (state_q)
      mlfq_pkg::StIdle:      cmd_o.load = in_valid_i;
      mlfq_pkg::StAddWr:     cmd_o.add_wr = !sts_i.mode;
      mlfq_pkg::StReqRd:     cmd_o.req_rd = 1'b1;
      mlfq_pkg::StReqWr:     cmd_o.req_wr = 1'b1;
      mlfq_pkg::StBoostChk:  cmd_o.boost_chk = 1'b1;
      mlfq_pkg::StBoostRd: begin
        if (sts_i.blvl_zero) cmd_o.boost_done = 1'b1;
        else if (sts_i.blvl_empty) cmd_o.lvl_dec = 1'b1;
        else if (sts_i.top_full) cmd_o.boost_done = 1'b1;
        else cmd_o.boost_rd = 1'b1;
      end
      mlfq_pkg::StBoostWait: ;
      mlfq_pkg::StBoostWr:   cmd_o.boost_wr = 1'b1;
      mlfq_pkg::StScan:      cmd_o.scan_step = !sts_i.slvl_found && !sts_i.slvl_zero;
      mlfq_pkg::StPopRd:     cmd_o.pop_rd = 1'b1;
      mlfq_pkg::StPopWait:   cmd_o.pop_fin = 1'b1;
      mlfq_pkg::StOut:       cmd_o.out_set = !sts_i.out_busy;
      default: ;
    endcase
  end
endmodule
`default_nettype wire

// ----- design/mlfq_dpath.sv -----
// Datapath: level queues, thread records, configuration and result register.
`default_nettype none
module mlfq_dpath (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [mlfq_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [mlfq_pkg::CfgW-1:0]     cfg_data_i,
  input  wire logic                          mode_i,
  input  wire logic [mlfq_pkg::TidW-1:0]     thread_id_i,
  input  wire logic                          last_done_i,
  input  wire logic [mlfq_pkg::RunW-1:0]     last_run_time_i,
  input  wire logic [mlfq_pkg::NowW-1:0]     now_i,
  input  wire mlfq_pkg::cmd_t                cmd_i,
  output mlfq_pkg::sts_t                     sts_o,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [mlfq_pkg::TidW-1:0]          next_thread_o,
  output logic                               has_thread_o,
  output logic                               queue_full_o
);
  localparam int unsigned TidW = mlfq_pkg::TidW;
  localparam int unsigned LvlW = mlfq_pkg::LvlW;
  localparam int unsigned CntW = mlfq_pkg::CntW;
  localparam int unsigned TimeW = mlfq_pkg::TimeW;
  localparam int unsigned MaxT = mlfq_pkg::MaxThreads;
  localparam int unsigned MaxL = mlfq_pkg::MaxLevels;

  logic [mlfq_pkg::NumLvW-1:0] num_levels_q;
  logic [TimeW-1:0]            allot_q;
  logic [mlfq_pkg::NowW-1:0]   period_q;

  logic [TidW-1:0] fifo_mem [MaxL*MaxT];
  logic [TidW-1:0] fifo_rd_q;
  logic [LvlW-1:0] tlvl_mem [MaxT];
  logic [TimeW-1:0] ttime_q [MaxT];
  logic [TidW-1:0] head_q [MaxL];
  logic [CntW-1:0] cnt_q [MaxL];

  logic            mode_q, done_q, full_q, found_q, boost_q;
  logic [TidW-1:0] tid_q, run_tid_q, next_q;
  logic            run_vld_q;
  logic [mlfq_pkg::RunW-1:0] run_q;
  logic [mlfq_pkg::NowW-1:0] now_q, stamp_q;
  logic [LvlW-1:0] blvl_q, slvl_q, rlvl_q;
  logic            out_vld_q;
  logic [TidW-1:0] out_tid_q;
  logic            out_has_q, out_full_q;

  logic [LvlW-1:0] top;
  logic [TimeW:0]  tsum;
  logic [TimeW-1:0] tsat;
  logic [LvlW-1:0] rl_clip, rl_new;
  logic            demote;
  logic [TidW-1:0] top_tail;
  logic [mlfq_pkg::NowW-1:0] elapsed;

  always_comb begin
    if (num_levels_q == '0) top = '0;
    else if (num_levels_q > mlfq_pkg::NumLvW'(MaxL)) top = LvlW'(MaxL - 1);
    else top = LvlW'(num_levels_q - 4'd1);
  end
  assign top_tail = TidW'(head_q[top] + TidW'(cnt_q[top]));
  assign tsum = {1'b0, ttime_q[run_tid_q]} + (TimeW+1)'(run_q);
  assign tsat = tsum[TimeW] ? '1 : tsum[TimeW-1:0];
  assign rl_clip = (rlvl_q > top) ? top : rlvl_q;
  assign demote = (tsat >= allot_q) && (rl_clip != '0);
  assign rl_new = demote ? rl_clip - 1'b1 : rl_clip;
  assign elapsed = now_q - stamp_q;

  always_comb begin
    sts_o = '0;
    sts_o.mode = mode_q;
    sts_o.requeue = run_vld_q && !done_q;
    sts_o.boost = (elapsed > period_q);
    sts_o.blvl_zero = (blvl_q == '0);
    sts_o.blvl_empty = (cnt_q[blvl_q - 1'b1] == '0);
    sts_o.top_full = (cnt_q[top] >= CntW'(MaxT));
    sts_o.slvl_zero = (slvl_q == '0);
    sts_o.slvl_found = (cnt_q[slvl_q] != '0);
    sts_o.out_busy = out_vld_q && out_stall_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_levels_q <= 4'd3;
      allot_q <= 24'd10000;
      period_q <= 32'd1000000;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mlfq_pkg::CfgNumLevels: num_levels_q <= cfg_data_i[mlfq_pkg::NumLvW-1:0];
        mlfq_pkg::CfgAllot:     allot_q <= cfg_data_i[TimeW-1:0];
        mlfq_pkg::CfgBoost:     period_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q <= mode_i; tid_q <= thread_id_i; done_q <= last_done_i;
      run_q <= last_run_time_i; now_q <= now_i;
    end
    if (cmd_i.add_wr && cnt_q[top] < CntW'(MaxT))
      fifo_mem[{top, top_tail}] <= tid_q;
    if (cmd_i.req_wr && cnt_q[rl_new] < CntW'(MaxT))
      fifo_mem[{rl_new, TidW'(head_q[rl_new] + TidW'(cnt_q[rl_new]))}] <= run_tid_q;
    if (cmd_i.boost_wr) fifo_mem[{top, top_tail}] <= fifo_rd_q;
    if (cmd_i.boost_rd)
      fifo_rd_q <= fifo_mem[{LvlW'(blvl_q - 1'b1), head_q[blvl_q - 1'b1]}];
    else if (cmd_i.pop_rd) fifo_rd_q <= fifo_mem[{slvl_q, head_q[slvl_q]}];
    if (cmd_i.add_wr) tlvl_mem[tid_q] <= top;
    if (cmd_i.req_wr) tlvl_mem[run_tid_q] <= rl_new;
    if (cmd_i.boost_wr) tlvl_mem[fifo_rd_q] <= top;
    if (cmd_i.req_rd) rlvl_q <= tlvl_mem[run_tid_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MaxL; i++) begin head_q[i] <= '0; cnt_q[i] <= '0; end
      for (int i = 0; i < MaxT; i++) ttime_q[i] <= '0;
      run_tid_q <= '0; run_vld_q <= 1'b0; stamp_q <= '0;
      full_q <= 1'b0; found_q <= 1'b0; next_q <= '0; boost_q <= 1'b0;
      blvl_q <= '0; slvl_q <= '0;
      out_vld_q <= 1'b0; out_tid_q <= '0; out_has_q <= 1'b0; out_full_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        full_q <= 1'b0; found_q <= 1'b0; next_q <= '0;
      end
      if (cmd_i.add_wr) begin
        ttime_q[tid_q] <= '0;
        if (cnt_q[top] < CntW'(MaxT)) cnt_q[top] <= cnt_q[top] + 1'b1;
        else full_q <= 1'b1;
      end
      if (cmd_i.req_wr) begin
        ttime_q[run_tid_q] <= demote ? '0 : tsat;
        if (cnt_q[rl_new] < CntW'(MaxT)) cnt_q[rl_new] <= cnt_q[rl_new] + 1'b1;
        else full_q <= 1'b1;
      end
      if (cmd_i.boost_chk) begin
        boost_q <= elapsed > period_q;
        blvl_q <= top;
        slvl_q <= top;
      end
      if (cmd_i.boost_rd) begin
        head_q[blvl_q - 1'b1] <= head_q[blvl_q - 1'b1] + 1'b1;
        cnt_q[blvl_q - 1'b1] <= cnt_q[blvl_q - 1'b1] - 1'b1;
      end
      if (cmd_i.lvl_dec) blvl_q <= blvl_q - 1'b1;
      if (cmd_i.boost_done && boost_q) begin
        stamp_q <= now_q;
        if (blvl_q != '0) full_q <= 1'b1;
      end
      if (cmd_i.boost_wr) begin
        cnt_q[top] <= cnt_q[top] + 1'b1;
        ttime_q[fifo_rd_q] <= '0;
      end
      if (cmd_i.scan_step) slvl_q <= slvl_q - 1'b1;
      if (cmd_i.pop_rd) begin
        head_q[slvl_q] <= head_q[slvl_q] + 1'b1;
        cnt_q[slvl_q] <= cnt_q[slvl_q] - 1'b1;
      end
      if (cmd_i.pop_fin) begin
        found_q <= 1'b1; next_q <= fifo_rd_q;
      end
      if (cmd_i.out_set) begin
        out_vld_q <= 1'b1;
        out_tid_q <= next_q; out_has_q <= found_q; out_full_q <= full_q;
        if (mode_q) begin
          run_vld_q <= found_q; run_tid_q <= next_q;
        end
      end else if (out_vld_q && !out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_vld_q;
  assign next_thread_o = out_tid_q;
  assign has_thread_o = out_has_q;
  assign queue_full_o = out_full_q;
endmodule
`default_nettype wire

// ----- design/mlfq_thread_scheduler.sv -----
// Top level of the multilevel feedback queue thread scheduler.
// One item is taken at a time. An add is captured, pushed onto the top level queue and
// its result set in the output register. A schedule re-queues the previously dispatched
// thread when it is still running, checks for a boost and, when one is due, moves the
// threads of the lower levels to the top level, then scans down past empty levels, pops
// the head of the first non-empty one and sets the result; with nothing to dispatch the pop
// drops out. The sequencer walks levels over one queue memory. The result waits in the
// output register until taken; the next item's result is set only after that.
`default_nettype none
module mlfq_thread_scheduler (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [mlfq_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [mlfq_pkg::CfgW-1:0]     cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic                          mode_i,
  input  wire logic [mlfq_pkg::TidW-1:0]     thread_id_i,
  input  wire logic                          last_done_i,
  input  wire logic [mlfq_pkg::RunW-1:0]     last_run_time_i,
  input  wire logic [mlfq_pkg::NowW-1:0]     now_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [mlfq_pkg::TidW-1:0]          next_thread_o,
  output logic                               has_thread_o,
  output logic                               queue_full_o
);
  mlfq_pkg::cmd_t cmd;
  mlfq_pkg::sts_t sts;

  mlfq_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .sts_i(sts), .cmd_o(cmd)
  );

  mlfq_dpath u_dpath (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .mode_i, .thread_id_i, .last_done_i, .last_run_time_i, .now_i,
    .cmd_i(cmd), .sts_o(sts), .out_valid_o, .out_stall_i,
    .next_thread_o, .has_thread_o, .queue_full_o
  );
endmodule
`default_nettype wire

// ----- dv/mlfq_thread_scheduler_tb.sv -----
// Self-checking testbench for the MLFQ thread scheduler: random and directed traffic.
module mlfq_thread_scheduler_tb;
  localparam int unsigned TidW = mlfq_pkg::TidW;
  localparam int unsigned RunW = mlfq_pkg::RunW;
  localparam int unsigned NowW = mlfq_pkg::NowW;
  localparam int unsigned CfgIdxW = mlfq_pkg::CfgIdxW;
  localparam int unsigned CfgW = mlfq_pkg::CfgW;
  localparam int unsigned NumLvW = mlfq_pkg::NumLvW;
  localparam int unsigned TimeW = mlfq_pkg::TimeW;
  localparam int unsigned MaxLevels = mlfq_pkg::MaxLevels;
  localparam int unsigned MaxThreads = mlfq_pkg::MaxThreads;

  typedef struct {
    logic             mode;
    logic [TidW-1:0]  tid;
    logic             done;
    logic [RunW-1:0]  run;
    logic [NowW-1:0]  now;
  } sched_req_t;

  typedef struct {
    logic [TidW-1:0] next_thread;
    logic            has_thread;
    logic            queue_full;
  } dispatch_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CfgW-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic mode_i = 1'b0;
  logic [TidW-1:0] thread_id_i = '0;
  logic last_done_i = 1'b0;
  logic [RunW-1:0] last_run_time_i = '0;
  logic [NowW-1:0] now_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [TidW-1:0] next_thread_o;
  logic has_thread_o;
  logic queue_full_o;

  mlfq_thread_scheduler u_top (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .mode_i, .thread_id_i, .last_done_i,
    .last_run_time_i, .now_i, .out_valid_o, .out_stall_i,
    .next_thread_o, .has_thread_o, .queue_full_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // scheduler shadow state
  logic [NumLvW-1:0] sh_levels = 4'd3;
  logic [TimeW-1:0]  sh_allot  = 24'd10000;
  logic [NowW-1:0]   sh_boost  = 32'd1000000;
  logic [TidW-1:0]   sh_fifo [MaxLevels][MaxThreads];
  int unsigned       sh_head [MaxLevels];
  int unsigned       sh_cnt  [MaxLevels];
  int unsigned       sh_tlvl [MaxThreads];
  int unsigned       sh_ttime[MaxThreads];
  logic [TidW-1:0]   sh_run_tid = '0;
  logic              sh_run_vld = 1'b0;
  logic [NowW-1:0]   sh_stamp = '0;

  sched_req_t pending_reqs[$];
  dispatch_t  dispatch_q[$];
  int unsigned mismatches = 0;
  logic idle_en = 1'b1;
  logic hold_go = 1'b0;
  int unsigned hold_left = 0;
  int unsigned in_gap = 0;
  int unsigned out_gap = 0;
  longint unsigned cycles = 0;
  logic [NowW-1:0] clock_us = '0;
  sched_req_t cur_req;

  function automatic bit push_lvl(int unsigned lvl, logic [TidW-1:0] tid);
    if (sh_cnt[lvl] >= MaxThreads) return 1'b0;
    sh_fifo[lvl][(sh_head[lvl] + sh_cnt[lvl]) % MaxThreads] = tid;
    sh_cnt[lvl]++;
    return 1'b1;
  endfunction

  function automatic logic [TidW-1:0] pop_lvl(int unsigned lvl);
    logic [TidW-1:0] tid;
    tid = sh_fifo[lvl][sh_head[lvl]];
    sh_head[lvl] = (sh_head[lvl] + 1) % MaxThreads;
    sh_cnt[lvl]--;
    return tid;
  endfunction

  function automatic void predict_dispatch(sched_req_t rq);
    int unsigned lv, top, sum, k, i;
    logic [TidW-1:0] t;
    dispatch_t r;
    lv = (sh_levels == 0) ? 1 : (sh_levels > MaxLevels) ? MaxLevels : sh_levels;
    top = lv - 1;
    r = '{next_thread: '0, has_thread: 1'b0, queue_full: 1'b0};
    if (rq.mode == 1'b0) begin
      sh_tlvl[rq.tid] = top;
      sh_ttime[rq.tid] = 0;
      if (!push_lvl(top, rq.tid)) r.queue_full = 1'b1;
      dispatch_q.push_back(r);
      return;
    end
    if (sh_run_vld && !rq.done) begin
      t = sh_run_tid;
      sum = sh_ttime[t] + rq.run;
      if (sum > 24'hFFFFFF) sum = 24'hFFFFFF;
      sh_ttime[t] = sum;
      if (sh_tlvl[t] > top) sh_tlvl[t] = top;
      if (sum >= sh_allot && sh_tlvl[t] > 0) begin
        sh_tlvl[t]--;
        sh_ttime[t] = 0;
      end
      if (!push_lvl(sh_tlvl[t], t)) r.queue_full = 1'b1;
    end
    if (NowW'(rq.now - sh_stamp) > sh_boost) begin
      for (k = top; k > 0; k--) begin
        while (sh_cnt[k-1] > 0) begin
          if (sh_cnt[top] >= MaxThreads) begin
            r.queue_full = 1'b1;
            break;
          end
          t = pop_lvl(k - 1);
          void'(push_lvl(top, t));
          sh_tlvl[t] = top;
          sh_ttime[t] = 0;
        end
      end
      sh_stamp = rq.now;
    end
    for (i = lv; i > 0 && !r.has_thread; i--) begin
      if (sh_cnt[i-1] > 0) begin
        r.next_thread = pop_lvl(i - 1);
        r.has_thread = 1'b1;
      end
    end
    sh_run_vld = r.has_thread;
    sh_run_tid = r.next_thread;
    dispatch_q.push_back(r);
  endfunction

  function automatic int unsigned draw_gap();
    return idle_en ? $urandom_range(0, 8) : 0;
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_gap <= 0;
    end else begin
      logic fire;
      fire = in_valid_i && !in_stall_o;
      if (fire) predict_dispatch(cur_req);
      if (!in_valid_i || fire) begin
        if (in_gap != 0) begin
          in_gap <= in_gap - 1;
          in_valid_i <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          cur_req = pending_reqs.pop_front();
          mode_i <= cur_req.mode;
          thread_id_i <= cur_req.tid;
          last_done_i <= cur_req.done;
          last_run_time_i <= cur_req.run;
          now_i <= cur_req.now;
          in_valid_i <= 1'b1;
          in_gap <= draw_gap();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (hold_go) hold_left <= 400;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  // monitor
  always @(posedge clk_i) begin
    int unsigned nxt_gap;
    dispatch_t exp_r;
    nxt_gap = (out_gap != 0) ? out_gap - 1 : 0;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      nxt_gap = draw_gap();
      if (dispatch_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transfer: next_thread %0d", next_thread_o);
      end else begin
        exp_r = dispatch_q.pop_front();
        if (exp_r.next_thread !== next_thread_o || exp_r.has_thread !== has_thread_o ||
            exp_r.queue_full !== queue_full_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp next %0d has %0d full %0d, got next %0d has %0d full %0d",
                     exp_r.next_thread, exp_r.has_thread, exp_r.queue_full,
                     next_thread_o, has_thread_o, queue_full_o);
        end
      end
    end
    out_gap <= nxt_gap;
    out_stall_i <= (hold_left > 1) || (nxt_gap != 0);
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 1500000) begin
      $display("mlfq_thread_scheduler_tb: errors");
      $finish;
    end
  end

  task automatic add_req(logic mode, logic [TidW-1:0] tid, logic done,
                         logic [RunW-1:0] run, logic [NowW-1:0] now);
    pending_reqs.push_back('{mode: mode, tid: tid, done: done, run: run, now: now});
  endtask

  task automatic write_cfg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      mlfq_pkg::CfgNumLevels: sh_levels = data[NumLvW-1:0];
      mlfq_pkg::CfgAllot:     sh_allot = data[TimeW-1:0];
      default:                sh_boost = data;
    endcase
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || in_valid_i || dispatch_q.size() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
  endtask

  task automatic random_traffic(int unsigned n);
    int unsigned j, r;
    for (j = 0; j < n; j++) begin
      r = $urandom_range(0, 99);
      if (r < 20) clock_us = clock_us + $urandom_range(0, 2000);
      else if (r < 27)
        clock_us = clock_us + NowW'(64'($urandom()) % (64'(sh_boost) + 64'd1));
      else if (r < 30) clock_us = $urandom();
      if ($urandom_range(0, 99) < 32)
        add_req(1'b0, TidW'($urandom_range(0, 15)), 1'($urandom()), RunW'($urandom()), clock_us);
      else
        add_req(1'b1, TidW'($urandom()), ($urandom_range(0, 3) == 0),
                ($urandom_range(0, 1) ? RunW'($urandom_range(0, 65535))
                                      : RunW'($urandom_range(0, 3000))), clock_us);
    end
  endtask

  initial begin
    logic [31:0] cfgs [7][3];
    int unsigned p, j;
    cfgs = '{'{3, 10000, 1000000}, '{8, 0, 0}, '{1, 24'hFFFFFF, 32'hFFFFFFFF},
             '{0, 500, 5000}, '{15, 3000, 20000}, '{2, 1, 300}, '{8, 2000, 100000}};
    for (j = 0; j < MaxLevels; j++) begin
      sh_head[j] = 0;
      sh_cnt[j] = 0;
    end
    for (j = 0; j < MaxThreads; j++) begin
      sh_tlvl[j] = 0;
      sh_ttime[j] = 0;
    end
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    // fill the top level past full, then dispatch across extremes of time
    for (j = 0; j < MaxThreads; j++) add_req(1'b0, TidW'(j), 1'b0, '0, '0);
    add_req(1'b0, 4'd15, 1'b1, 16'hFFFF, 32'hFFFFFFFF);
    add_req(1'b1, 4'd0, 1'b0, 16'hFFFF, 32'd0);
    add_req(1'b1, 4'd15, 1'b0, 16'd0, 32'd5);
    add_req(1'b1, 4'd0, 1'b1, 16'hFFFF, 32'd10);
    add_req(1'b1, 4'd0, 1'b0, 16'd9999, 32'hFFFFFFFF);
    add_req(1'b1, 4'd0, 1'b0, 16'd1, 32'd2000000);
    wait_drained();
    for (p = 0; p < 7; p++) begin
      idle_en = (p % 3) != 1;
      write_cfg(mlfq_pkg::CfgNumLevels, cfgs[p][0]);
      write_cfg(mlfq_pkg::CfgAllot, cfgs[p][1]);
      write_cfg(mlfq_pkg::CfgBoost, cfgs[p][2]);
      if (p == 3) begin
        @(posedge clk_i);
        hold_go <= 1'b1;
        @(posedge clk_i);
        hold_go <= 1'b0;
      end
      random_traffic(255);
      wait_drained();
    end
    repeat (50) @(posedge clk_i);
    if (mismatches == 0 && dispatch_q.size() == 0) begin
      $display("mlfq_thread_scheduler_tb: clean");
    end else begin
      $display("mlfq_thread_scheduler_tb: errors");
    end
    $finish;
  end
endmodule

// ----- files.f -----
design/mlfq_pkg.sv
design/mlfq_ctrl.sv
design/mlfq_dpath.sv
design/mlfq_thread_scheduler.sv
dv/mlfq_thread_scheduler_tb.sv
